FILE: rtl/tmrr_pkg.sv
// ----------------------------------------------------------------------------
// Tile map row renderer package
// Shared widths, codes, command and status structs and small helper
// functions for the tile map row renderer.
// ----------------------------------------------------------------------------
package tmrr_pkg;

  // Video memory geometry: two banks of fixed size.
  localparam int unsigned BANK_BYTES  = 8192;
  localparam int unsigned BANK_AW     = $clog2(BANK_BYTES);
  localparam int unsigned VRAM_DEPTH  = 2 * BANK_BYTES;
  localparam int unsigned VRAM_AW     = $clog2(VRAM_DEPTH);
  localparam int unsigned MAP_SIDE    = 32;

  // Default palette depth.
  localparam int unsigned PAL_ENTRIES_DEF = 64;

  // Payload widths.
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned VALUE_W  = 15;
  localparam int unsigned CELL_W   = $clog2(MAP_SIDE);
  localparam int unsigned LINE_W   = 3;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CIDX_W   = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 1;

  // Fixed addresses and attribute bits.
  localparam logic [BANK_AW-1:0] MAP_BASE_LOW        = 13'h1800;
  localparam logic [BANK_AW-1:0] MAP_BASE_HIGH       = 13'h1c00;
  localparam logic [BANK_AW-1:0] SIGNED_PATTERN_BASE = 13'h0800;
  localparam logic [7:0]         INDEX_FLIP          = 8'h80;
  localparam int unsigned ATTR_BANK_BIT  = 3;
  localparam int unsigned ATTR_XFLIP_BIT = 5;
  localparam int unsigned ATTR_YFLIP_BIT = 6;

  // Request codes on the item channel.
  typedef enum logic [REQ_W-1:0] {
    REQ_MEM_WRITE = 2'd0,
    REQ_PAL_WRITE = 2'd1,
    REQ_RENDER    = 2'd2
  } req_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE     = 2'd0,
    CFG_MAP_SELECT     = 2'd1,
    CFG_PATTERN_SELECT = 2'd2
  } cfg_idx_t;

  // Source of the video memory read address.
  typedef enum logic [1:0] {
    RD_TILE   = 2'd0,
    RD_ATTR   = 2'd1,
    RD_PAT_LO = 2'd2,
    RD_PAT_HI = 2'd3
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load_item;
    logic        vram_wr;
    logic        pal_wr;
    logic        vram_rd;
    rd_sel_t     rd_sel;
    logic        tile_cap;
    logic        attr_cap;
    logic        a_cap;
    logic        b_cap;
    logic        pix_adv;
    logic        pix_issue;
    logic [2:0]  pix_k;
  } tmrr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } tmrr_sts_t;

  // Mirror a byte for horizontal flip.
  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // Reduce a palette entry number (below 32) modulo the palette depth.
  // For a depth of at least four, eight conditional subtractions suffice.
  function automatic logic [CIDX_W-1:0] pal_mod(input logic [4:0] v,
                                                input int unsigned entries);
    logic [6:0] r;
    r = {2'b00, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= 7'(entries)) begin
        r = r - 7'(entries);
      end
    end
    return r[CIDX_W-1:0];
  endfunction

endpackage

FILE: rtl/tmrr_ifs.sv
// ----------------------------------------------------------------------------
// Tile map row renderer channels
// Valid/ready channels for request items, pixel results and register writes.
// ----------------------------------------------------------------------------

// Request item channel.
interface tmrr_in_if import tmrr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic                mem_bank;
  logic [BANK_AW-1:0]  write_address;
  logic [VALUE_W-1:0]  write_value;
  logic [CELL_W-1:0]   cell_row;
  logic [CELL_W-1:0]   cell_col;
  logic [LINE_W-1:0]   tile_line;

  modport source (
    output valid, req_type, mem_bank, write_address, write_value,
           cell_row, cell_col, tile_line,
    input  ready
  );
  modport sink (
    input  valid, req_type, mem_bank, write_address, write_value,
           cell_row, cell_col, tile_line,
    output ready
  );
endinterface

// Pixel result channel.
interface tmrr_out_if import tmrr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [CIDX_W-1:0]  color_index;
  logic               last;

  modport source (
    output valid, pixel_x, pixel_y, red, green, blue, color_index, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, red, green, blue, color_index, last,
    output ready
  );
endinterface

// Register write channel.
interface tmrr_cfg_if import tmrr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/tmrr_ctrl.sv
// ----------------------------------------------------------------------------
// Tile map row renderer controller
// Sequences the video memory reads of a render item and paces the eight
// pixel reads against the output register.
// ----------------------------------------------------------------------------
module tmrr_ctrl import tmrr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] in_req_type,
  output logic             in_ready,
  input  tmrr_sts_t        sts,
  output tmrr_cmd_t        cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MAP   = 9'b000000010,
    S_ATTR  = 9'b000000100,
    S_ATTRW = 9'b000001000,
    S_PATA  = 9'b000010000,
    S_PATB  = 9'b000100000,
    S_PATW  = 9'b001000000,
    S_PIX   = 9'b010000000,
    S_DRAIN = 9'b100000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] k;
  logic [2:0] k_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    k_next     = k;
    cmd        = '0;
    cmd.rd_sel = RD_TILE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (req_t'(in_req_type))
            REQ_MEM_WRITE: cmd.vram_wr = 1'b1;
            REQ_PAL_WRITE: cmd.pal_wr  = 1'b1;
            REQ_RENDER: begin
              cmd.load_item = 1'b1;
              state_next    = S_MAP;
            end
            default: ;
          endcase
        end
      end
      S_MAP: begin
        cmd.vram_rd = 1'b1;
        cmd.rd_sel  = RD_TILE;
        state_next  = S_ATTR;
      end
      S_ATTR: begin
        cmd.vram_rd  = 1'b1;
        cmd.rd_sel   = RD_ATTR;
        cmd.tile_cap = 1'b1;
        state_next   = S_ATTRW;
      end
      S_ATTRW: begin
        cmd.attr_cap = 1'b1;
        state_next   = S_PATA;
      end
      S_PATA: begin
        cmd.vram_rd = 1'b1;
        cmd.rd_sel  = RD_PAT_LO;
        state_next  = S_PATB;
      end
      S_PATB: begin
        cmd.vram_rd = 1'b1;
        cmd.rd_sel  = RD_PAT_HI;
        cmd.a_cap   = 1'b1;
        state_next  = S_PATW;
      end
      S_PATW: begin
        cmd.b_cap  = 1'b1;
        k_next     = 3'd0;
        state_next = S_PIX;
      end
      S_PIX: begin
        // Issue one palette read whenever the output stage can move.
        if (sts.out_free) begin
          cmd.pix_adv   = 1'b1;
          cmd.pix_issue = 1'b1;
          cmd.pix_k     = k;
          k_next        = k + 3'd1;
          if (k == 3'd7) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // Move the last palette word into the output register.
        if (sts.out_free) begin
          cmd.pix_adv = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and pixel counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= 3'd0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

endmodule

FILE: rtl/tmrr_datapath.sv
// ----------------------------------------------------------------------------
// Tile map row renderer datapath
// Holds the video memory, the palette memory, the configuration registers,
// the fetched tile bytes and the pixel output register.
// ----------------------------------------------------------------------------
module tmrr_datapath import tmrr_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tmrr_cmd_t             cmd,
  output tmrr_sts_t             sts,
  // Request payload
  input  logic                  mem_bank,
  input  logic [BANK_AW-1:0]    write_address,
  input  logic [VALUE_W-1:0]    write_value,
  input  logic [CELL_W-1:0]     cell_row,
  input  logic [CELL_W-1:0]     cell_col,
  input  logic [LINE_W-1:0]     tile_line,
  // Register writes
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Pixel results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      pixel_x,
  output logic [PIX_W-1:0]      pixel_y,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic [CIDX_W-1:0]     color_index,
  output logic                  last
);

  localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);

  logic color_mode;
  logic map_select;
  logic pattern_select;

  logic [7:0]          vram [VRAM_DEPTH];
  logic [VALUE_W-1:0]  pal_mem [PALETTE_ENTRIES];
  logic [VRAM_AW-1:0]  vram_rd_addr;
  logic [7:0]          vram_q;
  logic [VALUE_W-1:0]  pal_q;

  logic [CELL_W-1:0]   row;
  logic [CELL_W-1:0]   col;
  logic [LINE_W-1:0]   line;
  logic [7:0]          tile;
  logic [7:0]          attr;
  logic [7:0]          pat_a;
  logic [7:0]          pat_b;

  logic [BANK_AW-1:0]  map_addr;
  logic [7:0]          tile_idx;
  logic [LINE_W-1:0]   pline;
  logic [BANK_AW-1:0]  pat_addr;
  logic [2:0]          bit_sel;
  logic [4:0]          pix_entry;
  logic [CIDX_W-1:0]   pix_cidx;

  logic                pv;
  logic [2:0]          pal_k;
  logic [CIDX_W-1:0]   pal_c;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode     <= 1'b0;
      map_select     <= 1'b0;
      pattern_select <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COLOR_MODE:     color_mode     <= cfg_data[0];
        CFG_MAP_SELECT:     map_select     <= cfg_data[0];
        CFG_PATTERN_SELECT: pattern_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Address arithmetic for the map cell and the pattern line.
  always_comb begin
    map_addr = (map_select ? MAP_BASE_HIGH : MAP_BASE_LOW) + BANK_AW'({row, col});
    tile_idx = pattern_select ? (tile ^ INDEX_FLIP) : tile;
    pline    = attr[ATTR_YFLIP_BIT] ? ~line : line;
    pat_addr = (pattern_select ? SIGNED_PATTERN_BASE : '0)
             + BANK_AW'({tile_idx, pline, 1'b0});
  end

  // Video memory read address selection.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_TILE:   vram_rd_addr = {1'b0, map_addr};
      RD_ATTR:   vram_rd_addr = {1'b1, map_addr};
      RD_PAT_LO: vram_rd_addr = {attr[ATTR_BANK_BIT], pat_addr};
      RD_PAT_HI: vram_rd_addr = {attr[ATTR_BANK_BIT], pat_addr[BANK_AW-1:1], 1'b1};
      default:   vram_rd_addr = {1'b0, map_addr};
    endcase
  end

  // Video memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.vram_wr) begin
      vram[{mem_bank, write_address}] <= write_value[7:0];
    end
    if (cmd.vram_rd) begin
      vram_q <= vram[vram_rd_addr];
    end
  end

  // Latch the render item and the fetched bytes.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      row  <= cell_row;
      col  <= cell_col;
      line <= tile_line;
    end
    if (cmd.tile_cap) begin
      tile <= vram_q;
    end
    if (cmd.attr_cap) begin
      attr <= color_mode ? vram_q : 8'h00;
    end
    if (cmd.a_cap) begin
      pat_a <= attr[ATTR_XFLIP_BIT] ? reverse8(vram_q) : vram_q;
    end
    if (cmd.b_cap) begin
      pat_b <= attr[ATTR_XFLIP_BIT] ? reverse8(vram_q) : vram_q;
    end
  end

  // Palette entry of the pixel being issued; leftmost pixel is bit 7.
  always_comb begin
    bit_sel   = ~cmd.pix_k;
    pix_entry = {attr[2:0], pat_b[bit_sel], pat_a[bit_sel]};
    pix_cidx  = pal_mod(pix_entry, PALETTE_ENTRIES);
  end

  // Palette memory: writes in range only, registered read per pixel.
  always_ff @(posedge clk) begin
    if (cmd.pal_wr && (write_address < BANK_AW'(PALETTE_ENTRIES))) begin
      pal_mem[write_address[PAL_AW-1:0]] <= write_value;
    end
    if (cmd.pix_adv && cmd.pix_issue) begin
      pal_q <= pal_mem[pix_cidx[PAL_AW-1:0]];
      pal_k <= cmd.pix_k;
      pal_c <= pix_cidx;
    end
  end

  // Valid flags of the palette stage and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (cmd.pix_adv) begin
      pv        <= cmd.pix_issue;
      out_valid <= pv;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.pix_adv && pv) begin
      pixel_x     <= {col, pal_k};
      pixel_y     <= {row, line};
      red         <= {pal_q[4:0], 3'b000};
      green       <= {pal_q[9:5], 3'b000};
      blue        <= {pal_q[14:10], 3'b000};
      color_index <= pal_c;
      last        <= (pal_k == 3'd7);
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

FILE: rtl/tile_map_row_renderer_unit.sv
// ----------------------------------------------------------------------------
// Tile map row renderer
// Background tile line renderer with two video memory banks and a colour
// palette; each render request yields eight pixels from left to right.
// ----------------------------------------------------------------------------
//
//  Port    Dir   Transfer carries
//  item    in    memory write, palette write or render request
//  pixel   out   one rendered pixel with position, colour and last flag
//  cfg     in    register write (color_mode, map_select, pattern_select)
//
//  Writes complete in the cycle they are accepted. A render request holds
//  the input through four reads of the single video memory read port, one
//  palette read per pixel and one drain. Reset clears the configuration
//  registers, valid flags and control state; memory contents are undefined
//  until written. A stalled pixel output pauses the palette reads. A new
//  request is taken while the last pixel still waits in the output.
//
module tile_map_row_renderer_unit import tmrr_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tmrr_in_if.sink     item,
  tmrr_out_if.source  pixel,
  tmrr_cfg_if.sink    cfg
);

  tmrr_cmd_t cmd;
  tmrr_sts_t sts;

  // Register writes are always taken.
  assign cfg.ready = 1'b1;

  // Sequencer.
  tmrr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (item.valid),
    .in_req_type (item.req_type),
    .in_ready    (item.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Memories, registers and pixel output.
  tmrr_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mem_bank      (item.mem_bank),
    .write_address (item.write_address),
    .write_value   (item.write_value),
    .cell_row      (item.cell_row),
    .cell_col      (item.cell_col),
    .tile_line     (item.tile_line),
    .cfg_valid     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_valid     (pixel.valid),
    .out_ready     (pixel.ready),
    .pixel_x       (pixel.pixel_x),
    .pixel_y       (pixel.pixel_y),
    .red           (pixel.red),
    .green         (pixel.green),
    .blue          (pixel.blue),
    .color_index   (pixel.color_index),
    .last          (pixel.last)
  );

endmodule

FILE: tb/tmrr_pixel_checker.sv
// ----------------------------------------------------------------------------
// Tile map row renderer pixel checker
// Watches the request, register and pixel channels, keeps its own copy of
// video memory, palette and registers, predicts the eight pixels of every
// accepted render request and compares each pixel transfer in order.
// ----------------------------------------------------------------------------
module tmrr_pixel_checker import tmrr_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tmrr_in_if          item,
  tmrr_out_if         pixel,
  tmrr_cfg_if         cfg,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned pixels_checked
);

  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned PAL_AW       = $clog2(PALETTE_ENTRIES);

  typedef struct packed {
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [CIDX_W-1:0] cidx;
    logic              last;
  } pixel_t;

  // Mirror of the block's stores and registers.
  logic [7:0]         vram_mirror [2][BANK_BYTES];
  logic [VALUE_W-1:0] palette_mirror [PALETTE_ENTRIES];
  logic               color_mode;
  logic               map_select;
  logic               pattern_select;
  pixel_t             expected_pixels [$];

  function automatic string pixel_text(input pixel_t p);
    return $sformatf("x=%0d y=%0d rgb=%0d/%0d/%0d index=%0d last=%0b",
                     p.x, p.y, p.red, p.green, p.blue, p.cidx, p.last);
  endfunction

  // Work out the eight pixels of one tile line from the mirrored state.
  function automatic void predict_tile_line(input logic [CELL_W-1:0] row,
                                            input logic [CELL_W-1:0] col,
                                            input logic [LINE_W-1:0] line);
    logic [BANK_AW-1:0] map_addr;
    logic [BANK_AW-1:0] pat_addr;
    logic [7:0]         attrs;
    logic [7:0]         tile;
    logic [7:0]         a;
    logic [7:0]         b;
    logic [2:0]         pline;
    logic               bank;
    int unsigned        entry;
    logic [VALUE_W-1:0] colour;
    pixel_t             p;
    // Row and column side by side give row * 32 + column.
    map_addr = (map_select ? MAP_BASE_HIGH : MAP_BASE_LOW) + BANK_AW'({row, col});
    attrs = color_mode ? vram_mirror[1][map_addr] : 8'h00;
    tile = vram_mirror[0][map_addr];
    pat_addr = '0;
    if (pattern_select) begin
      tile = tile ^ INDEX_FLIP;
      pat_addr = SIGNED_PATTERN_BASE;
    end
    pline = attrs[ATTR_YFLIP_BIT] ? 3'd7 - line : line;
    // Sixteen bytes per tile, two bytes per line.
    pat_addr = pat_addr + BANK_AW'({tile, pline, 1'b0});
    bank = attrs[ATTR_BANK_BIT];
    a = vram_mirror[bank][pat_addr];
    b = vram_mirror[bank][pat_addr + 1'b1];
    if (attrs[ATTR_XFLIP_BIT]) begin
      a = {<<{a}};
      b = {<<{b}};
    end
    for (int k = 0; k < 8; k++) begin
      entry = 32'({b[7-k], a[7-k]});
      if (color_mode) begin
        entry = entry + attrs[2:0] * 4;
      end
      entry = entry % PALETTE_ENTRIES;
      colour = palette_mirror[PAL_AW'(entry)];
      p.x = {col, 3'(k)};
      p.y = {row, line};
      p.red = {colour[4:0], 3'b000};
      p.green = {colour[9:5], 3'b000};
      p.blue = {colour[14:10], 3'b000};
      p.cidx = CIDX_W'(entry);
      p.last = (k == 7);
      expected_pixels.push_back(p);
    end
  endfunction

  // Compare pixel transfers, then track register writes and requests.
  always @(posedge clk) begin : watch
    pixel_t got;
    pixel_t want;
    if (rst) begin
      color_mode = 1'b0;
      map_select = 1'b0;
      pattern_select = 1'b0;
      expected_pixels.delete();
      fail_count = 0;
      pixels_checked = 0;
    end else begin
      if (pixel.valid && pixel.ready) begin
        got = '{pixel.pixel_x, pixel.pixel_y, pixel.red, pixel.green, pixel.blue,
                pixel.color_index, pixel.last};
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected pixel at %0t: got %s", $time, pixel_text(got));
          end
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("pixel mismatch at %0t: expected %s, got %s", $time,
                       pixel_text(want), pixel_text(got));
            end
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_COLOR_MODE:     color_mode = cfg.data[0];
          CFG_MAP_SELECT:     map_select = cfg.data[0];
          CFG_PATTERN_SELECT: pattern_select = cfg.data[0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        case (item.req_type)
          REQ_MEM_WRITE: begin
            vram_mirror[item.mem_bank][item.write_address] = item.write_value[7:0];
          end
          REQ_PAL_WRITE: begin
            // Writes past the end of the palette are dropped.
            if (item.write_address < PALETTE_ENTRIES) begin
              palette_mirror[item.write_address[PAL_AW-1:0]] = item.write_value;
            end
          end
          REQ_RENDER: begin
            predict_tile_line(item.cell_row, item.cell_col, item.tile_line);
          end
          default: ;
        endcase
      end
    end
    pending = expected_pixels.size();
  end

endmodule

FILE: tb/tile_map_row_renderer_unit_tb.sv
// ----------------------------------------------------------------------------
// Tile map row renderer testbench
// Fills video memory and palette with random content so that every render
// only reads written entries, renders tile lines under all register
// settings with bursty requests and a stalling pixel sink, and lets the
// pixel checker compare every pixel against its own prediction.
// ----------------------------------------------------------------------------
module tile_map_row_renderer_unit_tb import tmrr_pkg::*; ();

  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned PHASE_ITEMS   = 32;
  localparam int unsigned N_PHASES      = 8;

  // Codes the block does not define, used to check that they are ignored.
  localparam logic [REQ_W-1:0]     REQ_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  logic clk;
  logic rst;

  tmrr_in_if  item ();
  tmrr_out_if pixel ();
  tmrr_cfg_if cfg ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned pixels_checked;

  // Stimulus-side image of memory contents, used to plan renders that
  // only touch written bytes and palette entries.
  logic [7:0] vram_image [2][BANK_BYTES];
  bit         vram_known [2][BANK_BYTES];
  bit         pal_known [PAL_ENTRIES_DEF];
  logic       color_mode;
  logic       map_select;
  logic       pattern_select;

  int unsigned burst_left;
  int unsigned requests_counted;
  int unsigned renders_sent;
  int unsigned vram_writes_sent;
  int unsigned palette_writes_sent;
  int unsigned unknown_sent;
  int unsigned settings_used;
  int unsigned stall_tick;
  int unsigned stall_mode;
  int unsigned cycle_count;

  tile_map_row_renderer_unit uut (
    .clk(clk),
    .rst(rst),
    .item(item),
    .pixel(pixel),
    .cfg(cfg)
  );

  tmrr_pixel_checker pixel_check (
    .clk(clk),
    .rst(rst),
    .item(item),
    .pixel(pixel),
    .cfg(cfg),
    .fail_count(fail_count),
    .pending(pending),
    .pixels_checked(pixels_checked)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pixel sink: ready follows a stall pattern that a tick counter redraws at random.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) begin
      stall_mode <= $urandom_range(0, 3);
    end
    case (stall_mode)
      0: pixel.ready <= 1'b1;
      1: pixel.ready <= 1'($urandom_range(0, 1));
      2: pixel.ready <= (stall_tick % 4 == 0);
      default: pixel.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Send one request. Requests go out in bursts with random gaps between.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic bank,
                              input logic [BANK_AW-1:0] addr,
                              input logic [VALUE_W-1:0] value,
                              input logic [CELL_W-1:0] row,
                              input logic [CELL_W-1:0] col,
                              input logic [LINE_W-1:0] line);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        item.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    item.valid <= 1'b1;
    item.req_type <= req;
    item.mem_bank <= bank;
    item.write_address <= addr;
    item.write_value <= value;
    item.cell_row <= row;
    item.cell_col <= col;
    item.tile_line <= line;
    do @(posedge clk); while (!item.ready);
    burst_left--;
    if (req == REQ_UNKNOWN) begin
      unknown_sent++;
    end else begin
      requests_counted++;
    end
  endtask

  task automatic send_vram_write(input logic bank, input logic [BANK_AW-1:0] addr,
                                 input logic [VALUE_W-1:0] value);
    vram_image[bank][addr] = value[7:0];
    vram_known[bank][addr] = 1'b1;
    vram_writes_sent++;
    send_request(REQ_MEM_WRITE, bank, addr, value, CELL_W'($urandom_range(0, 31)),
                 CELL_W'($urandom_range(0, 31)), LINE_W'($urandom_range(0, 7)));
  endtask

  task automatic send_palette_write(input logic [BANK_AW-1:0] addr,
                                    input logic [VALUE_W-1:0] value);
    if (addr < PAL_ENTRIES_DEF) begin
      pal_known[addr[CIDX_W-1:0]] = 1'b1;
    end
    palette_writes_sent++;
    send_request(REQ_PAL_WRITE, 1'($urandom_range(0, 1)), addr, value,
                 CELL_W'($urandom_range(0, 31)), CELL_W'($urandom_range(0, 31)),
                 LINE_W'($urandom_range(0, 7)));
  endtask

  // Write the map byte, attribute, pattern bytes and palette entries that
  // a render of this cell reads, then send the render. With fresh set the
  // bytes get new content; otherwise only missing ones are filled.
  // A non-negative attr_pick forces the attribute byte when color_mode is set.
  task automatic render_cell(input logic [CELL_W-1:0] row, input logic [CELL_W-1:0] col,
                             input logic [LINE_W-1:0] line, input bit fresh,
                             input int attr_pick);
    logic [BANK_AW-1:0] map_addr;
    logic [BANK_AW-1:0] pat_addr;
    logic [7:0]         attrs;
    logic [7:0]         tile;
    logic [2:0]         pline;
    logic               bank;
    int unsigned        entry;
    map_addr = (map_select ? MAP_BASE_HIGH : MAP_BASE_LOW) + BANK_AW'({row, col});
    if (fresh || !vram_known[0][map_addr]) begin
      send_vram_write(1'b0, map_addr, VALUE_W'($urandom_range(0, 32767)));
    end
    if (color_mode && (fresh || attr_pick >= 0 || !vram_known[1][map_addr])) begin
      send_vram_write(1'b1, map_addr,
                      VALUE_W'((attr_pick >= 0) ? attr_pick : $urandom_range(0, 32767)));
    end
    attrs = color_mode ? vram_image[1][map_addr] : 8'h00;
    tile = vram_image[0][map_addr] ^ (pattern_select ? INDEX_FLIP : 8'h00);
    pline = attrs[ATTR_YFLIP_BIT] ? 3'd7 - line : line;
    pat_addr = (pattern_select ? SIGNED_PATTERN_BASE : '0) + BANK_AW'({tile, pline, 1'b0});
    bank = attrs[ATTR_BANK_BIT];
    for (int j = 0; j < 2; j++) begin
      if (fresh || !vram_known[bank][pat_addr + BANK_AW'(j)]) begin
        send_vram_write(bank, pat_addr + BANK_AW'(j), VALUE_W'($urandom_range(0, 32767)));
      end
    end
    for (int k = 0; k < 8; k++) begin
      entry = 32'({vram_image[bank][pat_addr + 13'd1][k], vram_image[bank][pat_addr][k]});
      if (color_mode) begin
        entry = entry + attrs[2:0] * 4;
      end
      if (!pal_known[CIDX_W'(entry)]) begin
        send_palette_write(BANK_AW'(entry), VALUE_W'($urandom_range(0, 32767)));
      end
    end
    renders_sent++;
    send_request(REQ_RENDER, 1'($urandom_range(0, 1)), BANK_AW'($urandom_range(0, 8191)),
                 VALUE_W'($urandom_range(0, 32767)), row, col, line);
  endtask

  // Stop requests and wait until every pixel has come and the block is idle.
  task automatic drain_pixels();
    @(negedge clk);
    item.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Setting bits: color_mode, map_select, pattern_select from high to low.
  task automatic apply_setting(input logic [2:0] setting);
    drain_pixels();
    write_register(CFG_COLOR_MODE, setting[2]);
    write_register(CFG_MAP_SELECT, setting[1]);
    write_register(CFG_PATTERN_SELECT, setting[0]);
    color_mode = setting[2];
    map_select = setting[1];
    pattern_select = setting[0];
    settings_used++;
  endtask

  // End the run if it takes far longer than a correct block needs.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [2:0]  phase_settings [N_PHASES];
    int unsigned phase_end;
    int unsigned roll;
    logic [4:0]  row;
    logic [4:0]  col;
    phase_settings = '{3'b000, 3'b111, 3'b101, 3'b010, 3'b100, 3'b011, 3'b001, 3'b110};
    rst = 1'b1;
    item.valid = 1'b0;
    item.req_type = REQ_MEM_WRITE;
    item.mem_bank = 1'b0;
    item.write_address = '0;
    item.write_value = '0;
    item.cell_row = '0;
    item.cell_col = '0;
    item.tile_line = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_COLOR_MODE;
    cfg.data = '0;
    color_mode = 1'b0;
    map_select = 1'b0;
    pattern_select = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed part: corner cells, every flip combination, both attribute
    // banks, palette extremes, dropped palette writes and unknown codes.
    apply_setting(3'b111);
    write_register(CFG_UNUSED, 1'b1);
    render_cell(5'd31, 5'd31, 3'd7, 1'b1, 8'h6f);
    render_cell(5'd0, 5'd0, 3'd0, 1'b1, 8'h00);
    render_cell(5'd31, 5'd0, 3'd0, 1'b1, 8'h40);
    render_cell(5'd0, 5'd31, 3'd7, 1'b1, 8'h20);
    send_palette_write(13'd63, 15'h7fff);
    send_palette_write(13'd64, 15'h7fff);
    send_palette_write(13'h1fff, 15'h0000);
    send_request(REQ_UNKNOWN, 1'b1, 13'h1fff, 15'h7fff, 5'd31, 5'd31, 3'd7);
    send_vram_write(1'b1, 13'h1fff, 15'h7fff);
    apply_setting(3'b000);
    render_cell(5'd31, 5'd31, 3'd7, 1'b1, -1);
    render_cell(5'd0, 5'd0, 3'd0, 1'b1, -1);

    // Random part: one phase per register setting.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      apply_setting(phase_settings[ph]);
      phase_end = requests_counted + PHASE_ITEMS;
      while (requests_counted < phase_end) begin
        roll = $urandom_range(0, 99);
        row = CELL_W'($urandom_range(0, 31));
        col = CELL_W'($urandom_range(0, 31));
        if (roll < 50) begin
          render_cell(row, col, LINE_W'($urandom_range(0, 7)), 1'b1, -1);
        end else if (roll < 62) begin
          render_cell(row, col, LINE_W'($urandom_range(0, 7)), 1'b0, -1);
        end else if (roll < 77) begin
          send_vram_write(1'($urandom_range(0, 1)), BANK_AW'($urandom_range(0, 8191)),
                          VALUE_W'($urandom_range(0, 32767)));
        end else if (roll < 86) begin
          send_palette_write(BANK_AW'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                                           : $urandom_range(0, 8191)),
                             VALUE_W'($urandom_range(0, 32767)));
        end else if (roll < 91) begin
          send_request(REQ_UNKNOWN, 1'($urandom_range(0, 1)),
                       BANK_AW'($urandom_range(0, 8191)),
                       VALUE_W'($urandom_range(0, 32767)), row, col,
                       LINE_W'($urandom_range(0, 7)));
        end else if (roll < 94) begin
          drain_pixels();
        end else begin
          // Every line of one tile, top to bottom.
          for (int ln = 0; ln < 8; ln++) begin
            render_cell(row, col, LINE_W'(ln), 1'b0, -1);
          end
        end
      end
    end

    drain_pixels();
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    $display("Rendered %0d tile lines, %0d pixels checked, over %0d register settings.",
             renders_sent, pixels_checked, settings_used);
    $display("Sent %0d video memory writes, %0d palette writes, %0d unknown requests.",
             vram_writes_sent, palette_writes_sent, unknown_sent);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
